// ===== design/ura_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ura_pkg
// Shared types, constants and helpers of the upload ring allocator.
// ----------------------------------------------------------------------------
package ura_pkg;

  localparam int SLOTS       = 16;
  localparam int ALIGN_BYTES = 512;   // power of two
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int CNT_W       = SLOT_W + 1;

  localparam int OP_W    = 2;
  localparam int STAT_W  = 2;
  localparam int OFS_W   = 31;
  localparam int ID_W    = 4;
  localparam int BYTES_W = 32;
  localparam int FENCE_W = 64;
  localparam int SIZE_W  = 32;
  localparam int ALU_W   = FENCE_W + 1;

  localparam logic [SIZE_W-1:0]  SIZE_RESET = 32'd67108864;
  localparam logic [SIZE_W-1:0]  SIZE_MAX   = 32'h8000_0000;
  localparam logic [BYTES_W-1:0] ALIGN_LSB  = BYTES_W'(ALIGN_BYTES - 1);

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC  = 2'd0,
    OP_SUBMIT = 2'd1,
    OP_UPDATE = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK          = 2'd0,
    ST_NO_SLOT     = 2'd1,
    ST_NO_SPACE    = 2'd2,
    ST_NOT_PENDING = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_ORDER,
    S_A_FIT,
    S_A_WRAP,
    S_A_COMMIT,
    S_S_READ,
    S_S_STAMP,
    S_U_READ,
    S_U_CHECK,
    S_U_RETIRE,
    S_U_CLOSE,
    S_EMIT
  } state_e;

  // operands of the shared add / compare unit
  typedef struct packed {
    logic [FENCE_W-1:0] a;
    logic [FENCE_W-1:0] b;
    logic [ALU_W-1:0]   c;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] sum;
    logic             lt;
  } alu_res_t;

  typedef struct packed {
    logic [OFS_W-1:0]   offset;
    logic [BYTES_W-1:0] bytes;
    logic [FENCE_W-1:0] fence;
  } slot_rec_t;

  localparam int REC_W = $bits(slot_rec_t);

  typedef struct packed {
    status_e            status;
    logic [OFS_W-1:0]   ring_offset;
    logic [ID_W-1:0]    out_slot;
    logic [BYTES_W-1:0] aligned_bytes;
    logic [FENCE_W-1:0] fence_stamp;
    logic               retired;
    logic               last;
  } result_t;

  function automatic logic [BYTES_W-1:0] align_up(input logic [OFS_W-1:0] req);
    logic [BYTES_W-1:0] sum;
    sum = BYTES_W'(req) + ALIGN_LSB;
    return sum & ~ALIGN_LSB;
  endfunction

endpackage
`default_nettype wire

// ===== design/ura_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ura_if
// Request, response and configuration channels of the upload ring allocator.
// ----------------------------------------------------------------------------
interface ura_req_if;
  logic                        valid;
  logic                        ready;
  logic [ura_pkg::OP_W-1:0]    op;
  logic [ura_pkg::OFS_W-1:0]   request_bytes;
  logic [ura_pkg::ID_W-1:0]    slot_id;
  logic [ura_pkg::FENCE_W-1:0] completed_fence;

  modport source(output valid, op, request_bytes, slot_id, completed_fence, input ready);
  modport sink(input valid, op, request_bytes, slot_id, completed_fence, output ready);
endinterface

interface ura_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [ura_pkg::STAT_W-1:0]  status;
  logic [ura_pkg::OFS_W-1:0]   ring_offset;
  logic [ura_pkg::ID_W-1:0]    out_slot;
  logic [ura_pkg::BYTES_W-1:0] aligned_bytes;
  logic [ura_pkg::FENCE_W-1:0] fence_stamp;
  logic                        retired;
  logic                        last;

  modport source(output valid, status, ring_offset, out_slot, aligned_bytes, fence_stamp,
                 retired, last, input ready);
  modport sink(input valid, status, ring_offset, out_slot, aligned_bytes, fence_stamp,
               retired, last, output ready);
endinterface

interface ura_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [ura_pkg::SIZE_W-1:0] ring_size;

  modport source(output valid, ring_size, input ready);
  modport sink(input valid, ring_size, output ready);
endinterface
`default_nettype wire

// ===== design/upload_ring_allocator_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// steps, accepting edge to result in the output register: allocate orders, fits, may try the
//   wrap to offset 0, commits; submit reads, stamps; no free slot, slot not pending, op 3 emit
// update: read, check, retire per retired slot; close, after read and check if slots remain
// one item at a time: ready returns with the final result; the sequencer and its shared
//   add / compare unit set the rate, and result stalls hold it back
// reset (synchronous): pointers, counts, fence, submit flags cleared, ring 64 MiB; records kept
// ----------------------------------------------------------------------------
// upload_ring_allocator_top
// Aligned region allocator over a byte ring with fence-based in-order retire.
// ----------------------------------------------------------------------------
module upload_ring_allocator_top (
  input  wire logic clk,
  input  wire logic rst,
  ura_req_if.sink   req,
  ura_rsp_if.source rsp,
  ura_cfg_if.sink   cfg
);

  logic [ura_pkg::SIZE_W-1:0] ring_size;
  logic [ura_pkg::SIZE_W-1:0] eff_size;

  ura_pkg::alu_req_t  alu_req;
  ura_pkg::alu_res_t  alu_res;
  ura_pkg::slot_rec_t wr_data;
  ura_pkg::slot_rec_t rec;
  ura_pkg::result_t   res;
  ura_pkg::result_t   rsp_q;

  logic                       wr_en;
  logic                       rd_en;
  logic [ura_pkg::SLOT_W-1:0] wr_addr;
  logic [ura_pkg::SLOT_W-1:0] rd_addr;
  logic                       idle;
  logic                       emit;
  logic                       rsp_valid;
  logic                       out_free;

  assign cfg.ready = 1'b1;
  assign req.ready = idle;
  assign out_free  = !rsp_valid || rsp.ready;
  // sizes above 2 GiB behave as 2 GiB
  assign eff_size  = (ring_size > ura_pkg::SIZE_MAX) ? ura_pkg::SIZE_MAX : ring_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_size <= ura_pkg::SIZE_RESET;
    end else if (cfg.valid && cfg.ready) begin
      ring_size <= cfg.ring_size;
    end
  end

  ura_seq u_seq (
    .clk             (clk),
    .rst             (rst),
    .req_xfer        (req.valid && req.ready),
    .op              (req.op),
    .request_bytes   (req.request_bytes),
    .slot_id         (req.slot_id),
    .completed_fence (req.completed_fence),
    .idle            (idle),
    .eff_size        (eff_size),
    .alu_req         (alu_req),
    .alu_res         (alu_res),
    .wr_en           (wr_en),
    .wr_addr         (wr_addr),
    .wr_data         (wr_data),
    .rd_en           (rd_en),
    .rd_addr         (rd_addr),
    .rec             (rec),
    .out_free        (out_free),
    .emit            (emit),
    .res             (res)
  );

  ura_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  ura_ram #(
    .WIDTH (ura_pkg::REC_W),
    .DEPTH (ura_pkg::SLOTS)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rec)
  );

  // output register, refilled whenever it is empty or being drained
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_free) begin
      rsp_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && emit) begin
      rsp_q <= res;
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.status        = rsp_q.status;
  assign rsp.ring_offset   = rsp_q.ring_offset;
  assign rsp.out_slot      = rsp_q.out_slot;
  assign rsp.aligned_bytes = rsp_q.aligned_bytes;
  assign rsp.fence_stamp   = rsp_q.fence_stamp;
  assign rsp.retired       = rsp_q.retired;
  assign rsp.last          = rsp_q.last;

endmodule
`default_nettype wire

// ===== design/ura_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ura_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ura_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== design/ura_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ura_alu
// Shared add and compare unit: sum = a + b, lt = (a + b) < c.
// ----------------------------------------------------------------------------
module ura_alu (
  input  wire ura_pkg::alu_req_t req,
  output ura_pkg::alu_res_t      res
);

  logic [ura_pkg::ALU_W-1:0] sum;

  assign sum = {1'b0, req.a} + {1'b0, req.b};
  assign res = '{sum: sum, lt: (sum < req.c)};

endmodule
`default_nettype wire

// ===== design/ura_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ura_seq
// Sequencer: ring and slot pointers, fence counter, submit flags, and the
// step order that drives the shared add / compare unit and the slot RAM.
// ----------------------------------------------------------------------------
module ura_seq (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // request side
  input  wire logic                                req_xfer,
  input  wire logic [ura_pkg::OP_W-1:0]            op,
  input  wire logic [ura_pkg::OFS_W-1:0]           request_bytes,
  input  wire logic [ura_pkg::ID_W-1:0]            slot_id,
  input  wire logic [ura_pkg::FENCE_W-1:0]         completed_fence,
  output logic                                     idle,
  input  wire logic [ura_pkg::SIZE_W-1:0]          eff_size,
  // shared unit
  output ura_pkg::alu_req_t                        alu_req,
  input  wire ura_pkg::alu_res_t                   alu_res,
  // slot record RAM
  output logic                                     wr_en,
  output logic [ura_pkg::SLOT_W-1:0]               wr_addr,
  output ura_pkg::slot_rec_t                       wr_data,
  output logic                                     rd_en,
  output logic [ura_pkg::SLOT_W-1:0]               rd_addr,
  input  wire ura_pkg::slot_rec_t                  rec,
  // result towards the output register
  input  wire logic                                out_free,
  output logic                                     emit,
  output ura_pkg::result_t                         res
);

  ura_pkg::state_e state, state_next;

  logic [ura_pkg::OFS_W-1:0]   ring_head;
  logic [ura_pkg::OFS_W-1:0]   ring_tail;
  logic [ura_pkg::SLOT_W-1:0]  slot_head;
  logic [ura_pkg::CNT_W-1:0]   slot_count;
  logic [ura_pkg::FENCE_W-1:0] fence_counter;
  logic [ura_pkg::SLOTS-1:0]   submitted;

  logic [ura_pkg::BYTES_W-1:0] bytes_q;
  logic [ura_pkg::SLOT_W-1:0]  id_q;
  logic [ura_pkg::FENCE_W-1:0] done_q;
  ura_pkg::status_e            code_q;
  logic                        tlh_q;
  logic [ura_pkg::OFS_W-1:0]   pos_q;

  logic [ura_pkg::SLOT_W-1:0]  id_in;
  logic [ura_pkg::SLOT_W-1:0]  ahead;
  logic                        pending;
  logic                        full;
  logic [ura_pkg::SLOT_W-1:0]  alloc_idx;
  logic                        step;

  assign id_in     = ura_pkg::SLOT_W'(slot_id);
  assign ahead     = id_in - slot_head;
  assign pending   = (32'(slot_id) < ura_pkg::SLOTS) &&
                     ({1'b0, ahead} < slot_count) && !submitted[id_in];
  assign full      = slot_count == ura_pkg::CNT_W'(ura_pkg::SLOTS);
  assign alloc_idx = slot_head + slot_count[ura_pkg::SLOT_W-1:0];
  assign idle      = (state == ura_pkg::S_IDLE) && !rst;
  // result-producing states advance only when the output register is free
  assign step      = emit && out_free;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ura_pkg::S_IDLE: begin
        if (req_xfer) begin
          unique case (ura_pkg::op_e'(op))
            ura_pkg::OP_ALLOC:  state_next = full ? ura_pkg::S_EMIT : ura_pkg::S_A_ORDER;
            ura_pkg::OP_SUBMIT: state_next = pending ? ura_pkg::S_S_READ : ura_pkg::S_EMIT;
            ura_pkg::OP_UPDATE: state_next = (slot_count == '0) ? ura_pkg::S_U_CLOSE
                                                                : ura_pkg::S_U_READ;
            ura_pkg::OP_NONE:   state_next = ura_pkg::S_EMIT;
            default:            state_next = ura_pkg::S_EMIT;
          endcase
        end
      end
      ura_pkg::S_A_ORDER: state_next = ura_pkg::S_A_FIT;
      ura_pkg::S_A_FIT: begin
        priority if (alu_res.lt) state_next = ura_pkg::S_A_COMMIT;
        else if (tlh_q)          state_next = ura_pkg::S_EMIT;
        else                     state_next = ura_pkg::S_A_WRAP;
      end
      ura_pkg::S_A_WRAP: state_next = alu_res.lt ? ura_pkg::S_A_COMMIT : ura_pkg::S_EMIT;
      ura_pkg::S_A_COMMIT: if (out_free) state_next = ura_pkg::S_IDLE;
      ura_pkg::S_S_READ:   state_next = ura_pkg::S_S_STAMP;
      ura_pkg::S_S_STAMP:  if (out_free) state_next = ura_pkg::S_IDLE;
      ura_pkg::S_U_READ:   state_next = ura_pkg::S_U_CHECK;
      ura_pkg::S_U_CHECK: begin
        // stop at the first head slot not submitted or not yet completed
        if (!submitted[slot_head] || alu_res.lt) state_next = ura_pkg::S_U_CLOSE;
        else                                     state_next = ura_pkg::S_U_RETIRE;
      end
      ura_pkg::S_U_RETIRE: begin
        if (out_free) begin
          state_next = (slot_count == ura_pkg::CNT_W'(1)) ? ura_pkg::S_U_CLOSE
                                                          : ura_pkg::S_U_READ;
        end
      end
      ura_pkg::S_U_CLOSE: if (out_free) state_next = ura_pkg::S_IDLE;
      ura_pkg::S_EMIT:    if (out_free) state_next = ura_pkg::S_IDLE;
      default:            state_next = ura_pkg::S_IDLE;
    endcase
  end

  // unit operands, RAM access and result per state
  always_comb begin
    alu_req = '0;
    wr_en   = 1'b0;
    wr_addr = alloc_idx;
    wr_data = '0;
    rd_en   = 1'b0;
    rd_addr = slot_head;
    emit    = 1'b0;
    res     = '0;
    unique case (state)
      ura_pkg::S_IDLE: ;
      ura_pkg::S_A_ORDER: begin
        alu_req.a = ura_pkg::FENCE_W'(ring_tail);
        alu_req.c = ura_pkg::ALU_W'(ring_head);
      end
      ura_pkg::S_A_FIT: begin
        alu_req.a = ura_pkg::FENCE_W'(ring_tail);
        alu_req.b = ura_pkg::FENCE_W'(bytes_q);
        alu_req.c = tlh_q ? ura_pkg::ALU_W'(ring_head) : ura_pkg::ALU_W'(eff_size);
      end
      ura_pkg::S_A_WRAP: begin
        alu_req.a = ura_pkg::FENCE_W'(bytes_q);
        alu_req.c = ura_pkg::ALU_W'(ring_head);
      end
      ura_pkg::S_A_COMMIT: begin
        alu_req.a          = ura_pkg::FENCE_W'(pos_q);
        alu_req.b          = ura_pkg::FENCE_W'(bytes_q);
        emit               = 1'b1;
        wr_en              = out_free;
        wr_addr            = alloc_idx;
        wr_data.offset     = pos_q;
        wr_data.bytes      = bytes_q;
        res.status         = ura_pkg::ST_OK;
        res.ring_offset    = pos_q;
        res.out_slot       = ura_pkg::ID_W'(alloc_idx);
        res.aligned_bytes  = bytes_q;
        res.last           = 1'b1;
      end
      ura_pkg::S_S_READ: begin
        rd_en   = 1'b1;
        rd_addr = id_q;
      end
      ura_pkg::S_S_STAMP: begin
        alu_req.a          = fence_counter;
        alu_req.b          = ura_pkg::FENCE_W'(1);
        emit               = 1'b1;
        wr_en              = out_free;
        wr_addr            = id_q;
        wr_data.offset     = rec.offset;
        wr_data.bytes      = rec.bytes;
        wr_data.fence      = alu_res.sum[ura_pkg::FENCE_W-1:0];
        res.status         = ura_pkg::ST_OK;
        res.ring_offset    = rec.offset;
        res.out_slot       = ura_pkg::ID_W'(id_q);
        res.aligned_bytes  = rec.bytes;
        res.fence_stamp    = alu_res.sum[ura_pkg::FENCE_W-1:0];
        res.last           = 1'b1;
      end
      ura_pkg::S_U_READ: begin
        rd_en   = 1'b1;
        rd_addr = slot_head;
      end
      ura_pkg::S_U_CHECK: begin
        alu_req.a = done_q;
        alu_req.c = ura_pkg::ALU_W'(rec.fence);
      end
      ura_pkg::S_U_RETIRE: begin
        alu_req.a          = ura_pkg::FENCE_W'(rec.offset);
        alu_req.b          = ura_pkg::FENCE_W'(rec.bytes);
        alu_req.c          = ura_pkg::ALU_W'(eff_size);
        emit               = 1'b1;
        res.status         = ura_pkg::ST_OK;
        res.ring_offset    = rec.offset;
        res.out_slot       = ura_pkg::ID_W'(slot_head);
        res.aligned_bytes  = rec.bytes;
        res.fence_stamp    = rec.fence;
        res.retired        = 1'b1;
      end
      ura_pkg::S_U_CLOSE: begin
        emit            = 1'b1;
        res.status      = ura_pkg::ST_OK;
        res.ring_offset = ring_head;
        res.out_slot    = ura_pkg::ID_W'(slot_head);
        res.last        = 1'b1;
      end
      ura_pkg::S_EMIT: begin
        emit       = 1'b1;
        res.status = code_q;
        res.last   = 1'b1;
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ura_pkg::S_IDLE;
      ring_head     <= '0;
      ring_tail     <= '0;
      slot_head     <= '0;
      slot_count    <= '0;
      fence_counter <= '0;
      submitted     <= '0;
    end else begin
      state <= state_next;
      if (state == ura_pkg::S_A_COMMIT && step) begin
        ring_tail            <= alu_res.sum[ura_pkg::OFS_W-1:0];
        slot_count           <= slot_count + ura_pkg::CNT_W'(1);
        submitted[alloc_idx] <= 1'b0;
      end
      if (state == ura_pkg::S_S_STAMP && step) begin
        fence_counter   <= alu_res.sum[ura_pkg::FENCE_W-1:0];
        submitted[id_q] <= 1'b1;
      end
      if (state == ura_pkg::S_U_RETIRE && step) begin
        // head wraps to 0 once the region end reaches the ring end
        ring_head            <= alu_res.lt ? alu_res.sum[ura_pkg::OFS_W-1:0] : '0;
        submitted[slot_head] <= 1'b0;
        slot_head            <= slot_head + ura_pkg::SLOT_W'(1);
        slot_count           <= slot_count - ura_pkg::CNT_W'(1);
      end
    end
  end

  // per-item working registers
  always_ff @(posedge clk) begin
    if (state == ura_pkg::S_IDLE && req_xfer) begin
      bytes_q <= ura_pkg::align_up(request_bytes);
      id_q    <= id_in;
      done_q  <= completed_fence;
      priority case (ura_pkg::op_e'(op))
        ura_pkg::OP_ALLOC:  code_q <= ura_pkg::ST_NO_SLOT;
        ura_pkg::OP_SUBMIT: code_q <= ura_pkg::ST_NOT_PENDING;
        default:            code_q <= ura_pkg::ST_OK;
      endcase
    end
    if (state == ura_pkg::S_A_ORDER) begin
      tlh_q <= alu_res.lt;
    end
    if (state == ura_pkg::S_A_FIT) begin
      if (alu_res.lt) pos_q  <= ring_tail;
      else            code_q <= ura_pkg::ST_NO_SPACE;
    end
    if (state == ura_pkg::S_A_WRAP) begin
      if (alu_res.lt) pos_q  <= '0;
      else            code_q <= ura_pkg::ST_NO_SPACE;
    end
  end

endmodule
`default_nettype wire

// ===== design/ura_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ura_checker
// Port-level checks of the upload ring allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ura_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        req_valid,
  input wire logic                        req_ready,
  input wire logic                        rsp_valid,
  input wire logic                        rsp_ready,
  input wire logic [ura_pkg::STAT_W-1:0]  rsp_status,
  input wire logic [ura_pkg::OFS_W-1:0]   rsp_ring_offset,
  input wire logic [ura_pkg::ID_W-1:0]    rsp_out_slot,
  input wire logic [ura_pkg::BYTES_W-1:0] rsp_aligned_bytes,
  input wire logic [ura_pkg::FENCE_W-1:0] rsp_fence_stamp,
  input wire logic                        rsp_retired,
  input wire logic                        rsp_last
);

  // one item at a time: busy right after a request transfer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while an item is in progress");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_ring_offset) && $stable(rsp_out_slot) && $stable(rsp_aligned_bytes) &&
      $stable(rsp_fence_stamp) && $stable(rsp_retired) && $stable(rsp_last))
    else $error("stalled response changed");

  a_retire_notice: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_retired |-> !rsp_last && rsp_status == ura_pkg::ST_OK)
    else $error("retire notice closed the update or carried an error");

  a_refusal_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != ura_pkg::ST_OK |-> rsp_last && !rsp_retired &&
      rsp_ring_offset == '0 && rsp_out_slot == '0 && rsp_aligned_bytes == '0 &&
      rsp_fence_stamp == '0)
    else $error("refusal carried payload");

endmodule

bind upload_ring_allocator_top ura_checker u_ura_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_status        (rsp.status),
  .rsp_ring_offset   (rsp.ring_offset),
  .rsp_out_slot      (rsp.out_slot),
  .rsp_aligned_bytes (rsp.aligned_bytes),
  .rsp_fence_stamp   (rsp.fence_stamp),
  .rsp_retired       (rsp.retired),
  .rsp_last          (rsp.last)
);
`default_nettype wire
